// ===== rtl/core/awir_pkg.sv =====
// Shared types, constants and helper functions for the area-weighted resize block.
package awir_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int PIXEL_BITS     = 16;

  localparam int DIM_W     = 8;
  localparam int SCALE_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 9;
  localparam int IDX_W     = 9;
  localparam int OSZ_W     = 12;
  localparam int K_W       = 24;
  localparam int FRAC_W    = 16;
  localparam int WT_W      = 17;
  localparam int POS_W     = 35;
  localparam int FL_W      = POS_W - FRAC_W;
  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int SUM_W     = 48;
  localparam int WSUM_W    = 32;

  localparam logic [DIM_W-1:0]   RST_SRC_DIM = 8'd128;
  localparam logic [SCALE_W-1:0] RST_SCALE   = 11'd256;
  localparam logic [7:0]         ROUND_HALF  = 8'd128;
  localparam logic [WT_W-1:0]    ONE_Q16     = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_SCALE_Q8   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_MULX,
    ST_MULY,
    ST_POSY,
    ST_BOUND,
    ST_BASE,
    ST_RD,
    ST_WGT,
    ST_ACC,
    ST_END,
    ST_CMUL,
    ST_CRD,
    ST_CDATA,
    ST_DIVR
  } state_e;

  // Q1.16 coverage of source index idx by window [s, e)
  function automatic logic [WT_W-1:0] edge_wt(input logic [IDX_W-1:0] idx,
                                              input logic signed [FL_W-1:0] cs,
                                              input logic signed [FL_W-1:0] fe,
                                              input logic [FRAC_W-1:0] frs,
                                              input logic [FRAC_W-1:0] fre);
    logic signed [FL_W-1:0] si;
    si = $signed({{(FL_W-IDX_W){1'b0}}, idx});
    if (si < cs) return ONE_Q16 - {1'b0, frs};
    else if (si == fe && fre != '0) return {1'b0, fre};
    return ONE_Q16;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [FL_W-1:0] v,
                                                 input logic [IDX_W-1:0] hi);
    logic signed [FL_W-1:0] shi;
    shi = $signed({{(FL_W-IDX_W){1'b0}}, hi});
    if (v < 0) return '0;
    else if (v > shi) return hi;
    return v[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/awir_div.sv =====
// Restoring divider, one quotient bit per cycle.
module awir_div import awir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [WSUM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SUM_W - 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WSUM_W-1:0] rem_q, dvs_q;
  logic [SUM_W-1:0]  quo_q;
  logic [WSUM_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? WSUM_W'(trial - {1'b0, dvs_q}) : trial[WSUM_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/awir_mul.sv =====
// Shared multiplier with registered product.
module awir_mul import awir_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/area_weighted_image_resize.sv =====
// Area-weighted image resize: source store, sequencer, shared multiplier and divider.
//
// Usage: configure src_width, src_height and scale_q8 through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while idle. A request is taken when start_i is high and busy_o is low.
// A load request (req_type_i = 0) writes pixel_value_i into the store at the
// running raster index and gives no result; busy_o stays low.
// A compute request (req_type_i = 1) gives one result, shown on result_pixel_o and
// out_of_range_o for one cycle with done_o high; busy_o is low in that cycle.
// Out-of-range requests answer in the cycle after acceptance. Others run the two
// step-size divisions, the setup states, then for each covered source pixel one
// multiplier pass for the weight and one for weight*pixel (store read overlapped),
// then the final division, or a clamped corner-pixel store read when the window
// is empty or the weight sum is zero; the result shows in the cycle after that.
// The 48-step divider and the single multiplier set the length of this sequence.
// Reset clears the load index to zero and the registers to 128, 128 and 256;
// store contents are undefined until loaded. The receiver cannot stall results.
module area_weighted_image_resize import awir_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  req_type_i,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  input  logic [COORD_W-1:0]    out_x_i,
  input  logic [COORD_W-1:0]    out_y_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [PIXEL_BITS-1:0] result_pixel_o,
  output logic                  out_of_range_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e state_q, state_d;

  logic [DIM_W-1:0]   src_w_q, src_h_q;
  logic [SCALE_W-1:0] scale_q;
  logic [ADDR_W-1:0]  load_idx_q;
  logic               done_q, done_d;

  logic [COORD_W-1:0] x_q, y_q;
  logic [OSZ_W-1:0]   oh_q;
  logic [K_W-1:0]     kx_q, ky_q;
  logic signed [POS_W-1:0] sx_q, ex_q, sy_q, ey_q;
  logic [IDX_W-1:0]   i0_q, i1_q, j0_q, j1_q, i_q, j_q;
  logic [ADDR_W-1:0]  row_base_q;
  logic [SUM_W-1:0]   sum_q;
  logic [WSUM_W-1:0]  wsum_q;
  logic [PIXEL_BITS-1:0] res_q, rd_data_q;
  logic               oor_q;

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  // effective sizes
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic [IDX_W-1:0]      w9, h9;
  logic [DIM_W+SCALE_W-1:0] prod_w, prod_h;
  logic [OSZ_W-1:0]      ow_n, oh_n, ow_c, oh_c;
  logic [2*DIM_W-1:0]    wh;
  logic                  oob, load_acc, comp_acc;

  always_comb begin
    if (src_w_q == '0) w_eff = DIM_W'(1);
    else if (int'(src_w_q) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = src_w_q;
    if (src_h_q == '0) h_eff = DIM_W'(1);
    else if (int'(src_h_q) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = src_h_q;
  end

  assign w9     = {1'b0, w_eff};
  assign h9     = {1'b0, h_eff};
  assign prod_w = (DIM_W+SCALE_W)'(w_eff) * (DIM_W+SCALE_W)'(scale_q);
  assign prod_h = (DIM_W+SCALE_W)'(h_eff) * (DIM_W+SCALE_W)'(scale_q);
  // round half-down: up only when the fraction exceeds one half
  assign ow_n   = OSZ_W'(prod_w[DIM_W+SCALE_W-1:8]) + OSZ_W'(prod_w[7:0] > ROUND_HALF);
  assign oh_n   = OSZ_W'(prod_h[DIM_W+SCALE_W-1:8]) + OSZ_W'(prod_h[7:0] > ROUND_HALF);
  assign ow_c   = (ow_n == '0) ? OSZ_W'(1) : ow_n;
  assign oh_c   = (oh_n == '0) ? OSZ_W'(1) : oh_n;
  assign wh     = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
  assign oob    = (OSZ_W'(out_x_i) >= ow_c) || (OSZ_W'(out_y_i) >= oh_c);

  assign load_acc = (state_q == ST_IDLE) && start_i && !req_type_i;
  assign comp_acc = (state_q == ST_IDLE) && start_i && req_type_i;

  // window edges
  logic signed [FL_W-1:0]  fsx, fex, fsy, fey, csx, csy, eix, eiy;
  logic [FRAC_W-1:0]       frsx, frex, frsy, frey;
  logic signed [POS_W-1:0] half_x, half_y;

  assign fsx  = sx_q[POS_W-1:FRAC_W];
  assign fex  = ex_q[POS_W-1:FRAC_W];
  assign fsy  = sy_q[POS_W-1:FRAC_W];
  assign fey  = ey_q[POS_W-1:FRAC_W];
  assign frsx = sx_q[FRAC_W-1:0];
  assign frex = ex_q[FRAC_W-1:0];
  assign frsy = sy_q[FRAC_W-1:0];
  assign frey = ey_q[FRAC_W-1:0];
  assign csx  = fsx + $signed({{(FL_W-1){1'b0}}, |frsx});
  assign csy  = fsy + $signed({{(FL_W-1){1'b0}}, |frsy});
  assign eix  = fex + $signed({{(FL_W-1){1'b0}}, |frex});
  assign eiy  = fey + $signed({{(FL_W-1){1'b0}}, |frey});
  assign half_x = $signed({{(POS_W-K_W+1){1'b0}}, kx_q[K_W-1:1]});
  assign half_y = $signed({{(POS_W-K_W+1){1'b0}}, ky_q[K_W-1:1]});

  logic [WT_W-1:0] ax, ay;
  assign ax = edge_wt(i_q, csx, fex, frsx, frex);
  assign ay = edge_wt(j_q, csy, fey, frsy, frey);

  logic i_last, j_last;
  assign i_last = (i_q + IDX_W'(1)) == i1_q;
  assign j_last = (j_q + IDX_W'(1)) == j1_q;

  // shared units
  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_dvd, div_q;
  logic [WSUM_W-1:0]  div_dvs;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  awir_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  awir_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mul_a     = '0;
    mul_b     = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (state_q)
      ST_IDLE: begin
        if (comp_acc) begin
          if (oob) begin
            done_d = 1'b1;
          end else begin
            div_start = 1'b1;
            div_dvd   = {{(SUM_W-DIM_W-FRAC_W){1'b0}}, w_eff, {FRAC_W{1'b0}}};
            div_dvs   = WSUM_W'(ow_c);
            state_d   = ST_DIVX;
          end
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = {{(SUM_W-DIM_W-FRAC_W){1'b0}}, h_eff, {FRAC_W{1'b0}}};
          div_dvs   = WSUM_W'(oh_q);
          state_d   = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) state_d = ST_MULX;
      end
      ST_MULX: begin
        mul_a   = kx_q;
        mul_b   = MUL_B_W'(x_q);
        state_d = ST_MULY;
      end
      ST_MULY: begin
        mul_a   = ky_q;
        mul_b   = MUL_B_W'(y_q);
        state_d = ST_POSY;
      end
      ST_POSY: begin
        state_d = ST_BOUND;
      end
      ST_BOUND: begin
        mul_a   = MUL_A_W'(w_eff);
        mul_b   = MUL_B_W'(clamp_idx(fsy, h9));
        state_d = ST_BASE;
      end
      ST_BASE: begin
        if ((i0_q >= i1_q) || (j0_q >= j1_q)) state_d = ST_CMUL;
        else state_d = ST_RD;
      end
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(row_base_q + ADDR_W'(i_q));
        mul_a   = MUL_A_W'(ax);
        mul_b   = ay;
        state_d = ST_WGT;
      end
      ST_WGT: begin
        mul_a   = MUL_A_W'(mul_p[32:16]);
        mul_b   = MUL_B_W'(rd_data_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = (i_last && j_last) ? ST_END : ST_RD;
      end
      ST_END: begin
        if (wsum_q == '0) begin
          state_d = ST_CMUL;
        end else begin
          div_start = 1'b1;
          div_dvd   = sum_q;
          div_dvs   = wsum_q;
          state_d   = ST_DIVR;
        end
      end
      ST_CMUL: begin
        // zero weight or empty window: fall back to the clamped corner pixel
        mul_a   = MUL_A_W'(w_eff);
        mul_b   = MUL_B_W'(clamp_idx(fsy, h9 - IDX_W'(1)));
        state_d = ST_CRD;
      end
      ST_CRD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(ADDR_W'(mul_p) + ADDR_W'(clamp_idx(fsx, w9 - IDX_W'(1))));
        state_d = ST_CDATA;
      end
      ST_CDATA: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DIVR: begin
        if (div_done) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      load_idx_q <= '0;
      src_w_q    <= RST_SRC_DIM;
      src_h_q    <= RST_SRC_DIM;
      scale_q    <= RST_SCALE;
    end else begin
      done_q <= done_d;
      if (load_acc) begin
        if ((int'(load_idx_q) >= int'(wh)) || (int'(load_idx_q) + 1 >= int'(wh))) begin
          load_idx_q <= '0;
        end else begin
          load_idx_q <= load_idx_q + ADDR_W'(1);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SRC_WIDTH:  src_w_q <= cfg_wdata_i[DIM_W-1:0];
          CFG_SRC_HEIGHT: src_h_q <= cfg_wdata_i[DIM_W-1:0];
          CFG_SCALE_Q8:   scale_q <= cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) mem[load_idx_q] <= pixel_value_i;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (comp_acc) begin
          x_q   <= out_x_i;
          y_q   <= out_y_i;
          oh_q  <= oh_c;
          res_q <= '0;
          oor_q <= oob;
        end
      end
      ST_DIVX: if (div_done) kx_q <= div_q[K_W-1:0];
      ST_DIVY: if (div_done) ky_q <= div_q[K_W-1:0];
      ST_MULY: begin
        sx_q <= $signed({{(POS_W-33){1'b0}}, mul_p[32:0]}) - half_x;
        ex_q <= $signed({{(POS_W-33){1'b0}}, mul_p[32:0]}) + half_x;
      end
      ST_POSY: begin
        sy_q <= $signed({{(POS_W-33){1'b0}}, mul_p[32:0]}) - half_y;
        ey_q <= $signed({{(POS_W-33){1'b0}}, mul_p[32:0]}) + half_y;
      end
      ST_BOUND: begin
        i0_q <= clamp_idx(fsx, w9);
        i1_q <= clamp_idx(eix, w9);
        j0_q <= clamp_idx(fsy, h9);
        j1_q <= clamp_idx(eiy, h9);
      end
      ST_BASE: begin
        row_base_q <= ADDR_W'(mul_p);
        i_q        <= i0_q;
        j_q        <= j0_q;
        sum_q      <= '0;
        wsum_q     <= '0;
      end
      ST_WGT: wsum_q <= wsum_q + WSUM_W'(mul_p[32:16]);
      ST_ACC: begin
        sum_q <= sum_q + SUM_W'(mul_p[32:0]);
        if (!i_last) begin
          i_q <= i_q + IDX_W'(1);
        end else begin
          i_q        <= i0_q;
          j_q        <= j_q + IDX_W'(1);
          row_base_q <= ADDR_W'(row_base_q + ADDR_W'(w_eff));
        end
      end
      ST_CDATA: res_q <= rd_data_q;
      ST_DIVR: if (div_done) res_q <= div_q[PIXEL_BITS-1:0];
      default: ;
    endcase
  end

  assign busy_o         = state_q != ST_IDLE;
  assign done_o         = done_q;
  assign result_pixel_o = res_q;
  assign out_of_range_o = oor_q;

endmodule

// ===== rtl/core/awir_chk.sv =====
// Port-level checks for the resize block, bound to the top level.
module awir_chk import awir_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  req_type_i,
  input logic                  busy_o,
  input logic                  done_o,
  input logic [PIXEL_BITS-1:0] result_pixel_o,
  input logic                  out_of_range_o
);

  a_comp_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i) |=> (busy_o || done_o))
    else $error("compute request neither started nor answered");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !req_type_i) |=> !done_o)
    else $error("load request produced a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (result_pixel_o == '0))
    else $error("out-of-range result carries nonzero pixel");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && req_type_i))
    else $error("busy without compute request");

endmodule

bind area_weighted_image_resize awir_chk u_awir_chk (.*);
